### sv/ats_pkg.sv
// Shared types, register indexes and mode encodings for the transfer switch controller.
// No dependencies; every other file of the block imports this package.
package ats_pkg;

  // Widths of the item fields and registers
  localparam int unsigned TickW  = 32;
  localparam int unsigned VoltW  = 12;
  localparam int unsigned DelayW = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CfgW   = 16;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_TRIP_LOW       = 3'd0;
  localparam logic [IdxW-1:0] REG_TRIP_HIGH      = 3'd1;
  localparam logic [IdxW-1:0] REG_RETURN_LOW     = 3'd2;
  localparam logic [IdxW-1:0] REG_RETURN_HIGH    = 3'd3;
  localparam logic [IdxW-1:0] REG_TRIP_DELAY     = 3'd4;
  localparam logic [IdxW-1:0] REG_RETURN_DELAY   = 3'd5;
  localparam logic [IdxW-1:0] REG_SWITCH_DELAY   = 3'd6;
  localparam logic [IdxW-1:0] REG_OPEN_END_DELAY = 3'd7;

  // Reported mode codes
  localparam logic [ModeW-1:0] MODE_MAIN    = 2'd0;
  localparam logic [ModeW-1:0] MODE_TO_GEN  = 2'd1;
  localparam logic [ModeW-1:0] MODE_GEN     = 2'd2;
  localparam logic [ModeW-1:0] MODE_TO_MAIN = 2'd3;

  // Transfer sequence state, one-hot
  typedef enum logic [3:0] {
    ST_MAIN    = 4'b0001,
    ST_TO_GEN  = 4'b0010,
    ST_GEN     = 4'b0100,
    ST_TO_MAIN = 4'b1000
  } ats_mode_t;

  typedef struct packed {
    ats_mode_t         mode;
    logic [TickW-1:0]  phase_start;
    logic              phase_armed;
  } ats_state_t;

  typedef struct packed {
    logic [VoltW-1:0]  trip_low;
    logic [VoltW-1:0]  trip_high;
    logic [VoltW-1:0]  return_low;
    logic [VoltW-1:0]  return_high;
    logic [DelayW-1:0] trip_delay;
    logic [DelayW-1:0] return_delay;
    logic [DelayW-1:0] switch_delay;
    logic [DelayW-1:0] open_end_delay;
  } ats_cfg_t;

  typedef struct packed {
    logic              generator_running;
    logic [VoltW-1:0]  line_voltage;
    logic [TickW-1:0]  tick_ms;
  } ats_in_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              run_request;
    logic              transfer_relay;
    logic              generator_relay;
    logic              main_relay;
  } ats_res_t;

  // Map the one-hot state to the reported mode code.
  function automatic logic [ModeW-1:0] mode_code(input ats_mode_t m);
    logic [ModeW-1:0] code;
    unique case (m)
      ST_MAIN:    code = MODE_MAIN;
      ST_TO_GEN:  code = MODE_TO_GEN;
      ST_GEN:     code = MODE_GEN;
      ST_TO_MAIN: code = MODE_TO_MAIN;
      default:    code = MODE_MAIN;
    endcase
    return code;
  endfunction

endpackage

### sv/ats_cfg.sv
// Configuration register bank for the transfer switch controller.
// Depends on ats_pkg for the register indexes and the register struct.
module ats_cfg
  import ats_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_index,
  input  logic [CfgW-1:0] wr_data,
  output ats_cfg_t        regs
);

  // Register writes; each register keeps the low bits it needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trip_low       <= 12'd1080;
      regs.trip_high      <= 12'd1320;
      regs.return_low     <= 12'd1150;
      regs.return_high    <= 12'd1250;
      regs.trip_delay     <= 16'd500;
      regs.return_delay   <= 16'd2000;
      regs.switch_delay   <= 16'd1000;
      regs.open_end_delay <= 16'd2000;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRIP_LOW:       regs.trip_low       <= wr_data[VoltW-1:0];
        REG_TRIP_HIGH:      regs.trip_high      <= wr_data[VoltW-1:0];
        REG_RETURN_LOW:     regs.return_low     <= wr_data[VoltW-1:0];
        REG_RETURN_HIGH:    regs.return_high    <= wr_data[VoltW-1:0];
        REG_TRIP_DELAY:     regs.trip_delay     <= wr_data[DelayW-1:0];
        REG_RETURN_DELAY:   regs.return_delay   <= wr_data[DelayW-1:0];
        REG_SWITCH_DELAY:   regs.switch_delay   <= wr_data[DelayW-1:0];
        REG_OPEN_END_DELAY: regs.open_end_delay <= wr_data[DelayW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/ats_step.sv
// Combinational step of the transfer sequence: one item and the current state
// give the relay drives and the next state. Depends on ats_pkg.
module ats_step
  import ats_pkg::*;
(
  input  ats_state_t cur,
  input  ats_cfg_t   cfg,
  input  ats_in_t    item,
  output ats_state_t nxt,
  output ats_res_t   res
);

  logic [TickW-1:0] diff;
  logic [TickW-1:0] el_armed;
  logic             trip_bad;
  logic             ret_ok;

  // Elapsed time since the stamp; a timer armed in this step reads zero.
  assign diff     = item.tick_ms - cur.phase_start;
  assign el_armed = cur.phase_armed ? diff : '0;

  // Voltage window checks
  assign trip_bad = (item.line_voltage < cfg.trip_low) ||
                    (item.line_voltage > cfg.trip_high);
  assign ret_ok   = (item.line_voltage >= cfg.return_low) &&
                    (item.line_voltage <= cfg.return_high);

  // Sequence update and relay drives
  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.mode)
      ST_MAIN: begin
        res.main_relay = 1'b1;
        if (trip_bad) begin
          if (!cur.phase_armed) begin
            nxt.phase_start = item.tick_ms;
            nxt.phase_armed = 1'b1;
          end
          if (el_armed >= {16'd0, cfg.trip_delay}) begin
            res.main_relay  = 1'b0;
            nxt.mode        = ST_TO_GEN;
            nxt.phase_armed = 1'b0;
          end
        end else begin
          nxt.phase_armed = 1'b0;
        end
      end
      ST_TO_GEN: begin
        res.run_request = 1'b1;
        if (!item.generator_running) begin
          nxt.phase_armed = 1'b0;
        end else if (!cur.phase_armed) begin
          nxt.phase_start     = item.tick_ms;
          nxt.phase_armed     = 1'b1;
          res.generator_relay = 1'b1;
        end else begin
          res.generator_relay = 1'b1;
          if (diff >= {16'd0, cfg.switch_delay}) begin
            res.transfer_relay = 1'b1;
            nxt.mode           = ST_GEN;
            nxt.phase_armed    = 1'b0;
          end
        end
      end
      ST_GEN: begin
        res.generator_relay = 1'b1;
        res.transfer_relay  = 1'b1;
        res.run_request     = 1'b1;
        if (ret_ok) begin
          if (!cur.phase_armed) begin
            nxt.phase_start = item.tick_ms;
            nxt.phase_armed = 1'b1;
          end
          if (el_armed >= {16'd0, cfg.return_delay}) begin
            res.transfer_relay = 1'b0;
            nxt.mode           = ST_TO_MAIN;
            nxt.phase_start    = item.tick_ms;
            nxt.phase_armed    = 1'b1;
          end
        end else begin
          nxt.phase_armed = 1'b0;
        end
      end
      ST_TO_MAIN: begin
        // Break before make: hold the generator, open everything, then close main.
        if (diff < {16'd0, cfg.switch_delay}) begin
          res.generator_relay = 1'b1;
        end else if (diff >= {16'd0, cfg.open_end_delay}) begin
          res.main_relay  = 1'b1;
          nxt.mode        = ST_MAIN;
          nxt.phase_armed = 1'b0;
        end
      end
      default: begin
        nxt.mode        = ST_MAIN;
        nxt.phase_armed = 1'b0;
      end
    endcase
    res.mode = mode_code(nxt.mode);
  end

endmodule

### sv/automatic_transfer_switch_controller.sv
// Top level of the automatic transfer switch controller: stream ports, input and
// result registers, sequence state. Depends on ats_pkg, ats_cfg and ats_step.
//
// Usage:
//   Input items arrive on the s_t* channel, one sample per item: a millisecond
//   timestamp, the main line RMS voltage and the generator running flag.
//   Each item yields exactly one result item on the m_t* channel with the main,
//   generator and transfer relay drives, the generator run request and the
//   mode after the step.
//   An item is held in an input register, then the sequence step is computed
//   combinationally into the result register, which drives m_tvalid. While the
//   receiver takes results, one item is accepted every cycle.
//   When the receiver holds m_tready low, the result register keeps its item
//   and the input register still takes one more item; after that s_tready
//   drops until the result is taken. Nothing is lost or repeated.
//   Thresholds and delays are written on the cfg_* channel, which is always
//   ready; write them only while no item is in flight.
//   Reset empties both registers, puts the sequence on main with the timer
//   disarmed and loads the default thresholds and delays.
module automatic_transfer_switch_controller
  import ats_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  // Input items
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [47:0]     s_tdata,   // tick_ms[31:0], line_voltage[43:32],
                                     // generator_running[44], zero fill[47:45]
  // Result items
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // main_relay[0], generator_relay[1],
                                     // transfer_relay[2], run_request[3],
                                     // mode[5:4], zero fill[7:6]
  // Configuration writes
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  ats_cfg_t   regs;
  ats_state_t state;
  ats_state_t state_next;
  ats_in_t    in_item;
  logic       in_valid;
  ats_res_t   res_next;
  ats_res_t   out_res;
  logic       out_valid;
  logic       advance;

  // Configuration bank
  assign cfg_ready = 1'b1;

  ats_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  // Sequence step logic
  ats_step u_step (
    .cur  (state),
    .cfg  (regs),
    .item (in_item),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Pipeline flow: the held item moves on when the result register frees up.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_tdata[44:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  // Sequence state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= ST_MAIN;
      state.phase_start <= '0;
      state.phase_armed <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res};

`ifndef SYNTHESIS
  // Main and generator sources are never closed together.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("main and generator relays closed together");

  // The load moves to the generator only through a closed generator relay.
  a_transfer_on_gen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("transfer relay closed without generator relay");

  // A held item is kept while the result side stalls.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_tready |=> in_valid)
    else $error("input item dropped during output stall");
`endif

endmodule
